@@ rtl/aat_pkg.sv @@
`timescale 1ns / 1ps

package aat_pkg;

   // table geometry
   localparam int TABLE_ENTRIES = 64;
   localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);

   // field widths
   localparam int KEY_W     = 32;
   localparam int TIME_W    = 32;
   localparam int WORD_W    = KEY_W + TIME_W;
   localparam int OP_W      = 2;
   localparam int STATUS_W  = 2;
   localparam int ENTRIES_W = 7;

   // configuration port
   localparam int CSR_INDEX_W = 8;
   localparam int CSR_DATA_W  = 32;

   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_AGE        = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_JUMP_THRESHOLD = CSR_INDEX_W'(1);

   localparam logic [TIME_W-1:0] MAX_AGE_RESET        = TIME_W'(60 * 60 * 12);
   localparam logic [TIME_W-1:0] JUMP_THRESHOLD_RESET = TIME_W'(100);

   typedef enum logic [OP_W-1:0] {
      OP_ADD    = 2'd0,
      OP_UPDATE = 2'd1,
      OP_DELETE = 2'd2,
      OP_TICK   = 2'd3
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_FULL      = 2'd2
   } status_type;

   typedef struct packed {
      op_type            op;
      logic [KEY_W-1:0]  key;
      logic [TIME_W-1:0] now;
   } cmd_type;

   typedef struct packed {
      status_type       status;
      logic [CNT_W-1:0] count;
   } result_type;

   typedef struct packed {
      logic [TIME_W-1:0] max_age;
      logic [TIME_W-1:0] jump_threshold;
   } cfg_type;

endpackage

@@ rtl/aat_if.sv @@
`timescale 1ns / 1ps

// request channel
interface aat_req_if;
   logic                          valid;
   logic                          ready;
   logic [aat_pkg::OP_W-1:0]      operation;
   logic [aat_pkg::KEY_W-1:0]     ip_address;
   logic [aat_pkg::TIME_W-1:0]    current_time;

   modport source (output valid, output operation, output ip_address,
                   output current_time, input ready);
   modport sink   (input valid, input operation, input ip_address,
                   input current_time, output ready);
endinterface

// response channel
interface aat_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [aat_pkg::STATUS_W-1:0]  status;
   logic [aat_pkg::ENTRIES_W-1:0] entries_in_use;

   modport source (output valid, output status, output entries_in_use, input ready);
   modport sink   (input valid, input status, input entries_in_use, output ready);
endinterface

// configuration write channel
interface aat_csr_if;
   logic                            valid;
   logic                            ready;
   logic [aat_pkg::CSR_INDEX_W-1:0] index;
   logic [aat_pkg::CSR_DATA_W-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/aging_address_table.sv @@
// A request is taken only while the engine is idle; the next request is not accepted until
// the previous one has finished. Every operation scans each table entry once through the
// single read port of the key/stamp memory.
// A finished response waits in an output register while the next request is taken.
// Reset (synchronous, active high): table empty, last tick time zero, max_age 43200,
// jump_threshold 100; no clearing pass, the valid bits clear at once.
`timescale 1ns / 1ps

module aging_address_table (
   input  logic     clock,
   input  logic     reset,
   aat_req_if.sink  req_ch,
   aat_rsp_if.source rsp_ch,
   aat_csr_if.sink  csr_ch
);

   aat_pkg::cfg_type    cfg;
   aat_pkg::cmd_type    cmd;
   aat_pkg::result_type result;
   logic                idle;
   logic                done;
   logic                start;
   logic                rsp_free;

   logic                               rsp_valid_ff, rsp_valid_in;
   logic [aat_pkg::STATUS_W-1:0]       rsp_status_ff, rsp_status_in;
   logic [aat_pkg::ENTRIES_W-1:0]      rsp_count_ff, rsp_count_in;

   aat_csr u_csr (
      .clock  (clock),
      .reset  (reset),
      .csr_ch (csr_ch),
      .cfg_o  (cfg)
   );

   // accept a request beat whenever the engine is idle
   assign req_ch.ready = idle;
   assign start        = req_ch.valid && idle;
   assign cmd.op       = aat_pkg::op_type'(req_ch.operation);
   assign cmd.key      = req_ch.ip_address;
   assign cmd.now      = req_ch.current_time;

   assign rsp_free = !rsp_valid_ff || rsp_ch.ready;

   aat_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .cfg_i      (cfg),
      .start_i    (start),
      .cmd_i      (cmd),
      .rsp_free_i (rsp_free),
      .idle_o     (idle),
      .done_o     (done),
      .result_o   (result)
   );

   // load the output register on completion, drop it once taken
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      if (done) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = result.status;
         rsp_count_in  = aat_pkg::ENTRIES_W'(result.count);
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.status         = rsp_status_ff;
   assign rsp_ch.entries_in_use = rsp_count_ff;

endmodule

@@ rtl/aat_csr.sv @@
`timescale 1ns / 1ps

module aat_csr (
   input  logic             clock,
   input  logic             reset,
   aat_csr_if.sink          csr_ch,
   output aat_pkg::cfg_type cfg_o
);

   aat_pkg::cfg_type cfg_ff;
   aat_pkg::cfg_type cfg_in;

   // always take a write beat
   assign csr_ch.ready = 1'b1;

   // decode the register index, drop writes beyond the list
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_ch.valid) begin
         case (csr_ch.index)
            aat_pkg::CSR_MAX_AGE:        cfg_in.max_age        = csr_ch.data;
            aat_pkg::CSR_JUMP_THRESHOLD: cfg_in.jump_threshold = csr_ch.data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_age        <= aat_pkg::MAX_AGE_RESET;
         cfg_ff.jump_threshold <= aat_pkg::JUMP_THRESHOLD_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg_o = cfg_ff;

endmodule

@@ rtl/aat_engine.sv @@
`timescale 1ns / 1ps

module aat_engine (
   input  logic                clock,
   input  logic                reset,
   input  aat_pkg::cfg_type    cfg_i,
   input  logic                start_i,
   input  aat_pkg::cmd_type    cmd_i,
   input  logic                rsp_free_i,
   output logic                idle_o,
   output logic                done_o,
   output aat_pkg::result_type result_o
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_FINISH,
      S_DONE
   } state_type;

   localparam logic [aat_pkg::IDX_W-1:0] LAST_IDX = aat_pkg::IDX_W'(aat_pkg::TABLE_ENTRIES - 1);

   state_type                           state_ff, state_in;
   aat_pkg::cmd_type                    cmd_ff, cmd_in;
   logic                                restamp_ff, restamp_in;
   logic [aat_pkg::TIME_W-1:0]          last_tick_ff, last_tick_in;
   logic                                issuing_ff, issuing_in;
   logic [aat_pkg::IDX_W-1:0]           issue_idx_ff, issue_idx_in;
   logic                                cmp_valid_ff, cmp_valid_in;
   logic [aat_pkg::IDX_W-1:0]           cmp_idx_ff, cmp_idx_in;
   logic                                found_ff, found_in;
   logic [aat_pkg::IDX_W-1:0]           found_idx_ff, found_idx_in;
   logic                                free_ff, free_in;
   logic [aat_pkg::IDX_W-1:0]           free_idx_ff, free_idx_in;
   logic [aat_pkg::TABLE_ENTRIES-1:0]   valid_ff, valid_in;
   logic [aat_pkg::CNT_W-1:0]           count_ff, count_in;
   aat_pkg::status_type                 status_ff, status_in;

   // key and stamp storage, one word per entry
   logic [aat_pkg::WORD_W-1:0]          mem [aat_pkg::TABLE_ENTRIES];
   logic [aat_pkg::WORD_W-1:0]          rd_data_ff;
   logic                                mem_we;
   logic [aat_pkg::IDX_W-1:0]           mem_wa;
   logic [aat_pkg::WORD_W-1:0]          mem_wd;

   logic [aat_pkg::KEY_W-1:0]           key_rd;
   logic [aat_pkg::TIME_W-1:0]          stamp_rd;
   logic                                ent_valid;
   logic [aat_pkg::TIME_W:0]            age_sum;
   logic [aat_pkg::TIME_W:0]            jump_sum;
   logic                                expired;
   logic                                jumped;

   assign key_rd    = rd_data_ff[aat_pkg::WORD_W-1:aat_pkg::TIME_W];
   assign stamp_rd  = rd_data_ff[aat_pkg::TIME_W-1:0];
   assign ent_valid = valid_ff[cmp_idx_ff];

   // time compares without wrap
   assign age_sum  = {1'b0, stamp_rd} + {1'b0, cfg_i.max_age};
   assign expired  = age_sum < {1'b0, cmd_ff.now};
   assign jump_sum = {1'b0, last_tick_ff} + {1'b0, cfg_i.jump_threshold};
   assign jumped   = jump_sum < {1'b0, cmd_i.now};

   // next state of the scan sequencer
   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      restamp_in   = restamp_ff;
      last_tick_in = last_tick_ff;
      issuing_in   = issuing_ff;
      issue_idx_in = issue_idx_ff;
      cmp_valid_in = 1'b0;
      cmp_idx_in   = cmp_idx_ff;
      found_in     = found_ff;
      found_idx_in = found_idx_ff;
      free_in      = free_ff;
      free_idx_in  = free_idx_ff;
      valid_in     = valid_ff;
      count_in     = count_ff;
      status_in    = status_ff;
      mem_we       = 1'b0;
      mem_wa       = cmp_idx_ff;
      mem_wd       = {key_rd, cmd_ff.now};

      case (state_ff)
         S_IDLE: begin
            if (start_i) begin
               cmd_in       = cmd_i;
               restamp_in   = jumped;
               if (cmd_i.op == aat_pkg::OP_TICK) begin
                  last_tick_in = cmd_i.now;
               end
               issuing_in   = 1'b1;
               issue_idx_in = '0;
               found_in     = 1'b0;
               free_in      = 1'b0;
               status_in    = aat_pkg::ST_OK;
               state_in     = S_SCAN;
            end
         end

         S_SCAN: begin
            // advance the read pointer
            cmp_valid_in = issuing_ff;
            cmp_idx_in   = issue_idx_ff;
            if (issuing_ff) begin
               if (issue_idx_ff == LAST_IDX) begin
                  issuing_in = 1'b0;
               end else begin
                  issue_idx_in = issue_idx_ff + aat_pkg::IDX_W'(1);
               end
            end

            // examine the entry read last cycle
            if (cmp_valid_ff) begin
               if (cmd_ff.op == aat_pkg::OP_TICK) begin
                  if (ent_valid) begin
                     if (restamp_ff) begin
                        mem_we = 1'b1;
                     end else if (expired) begin
                        valid_in[cmp_idx_ff] = 1'b0;
                        count_in = count_ff - aat_pkg::CNT_W'(1);
                     end
                  end
               end else begin
                  if (ent_valid && (key_rd == cmd_ff.key) && !found_ff) begin
                     found_in     = 1'b1;
                     found_idx_in = cmp_idx_ff;
                  end
                  if (!ent_valid && !free_ff) begin
                     free_in     = 1'b1;
                     free_idx_in = cmp_idx_ff;
                  end
               end
               if (cmp_idx_ff == LAST_IDX) begin
                  state_in = S_FINISH;
               end
            end
         end

         S_FINISH: begin
            mem_wd = {cmd_ff.key, last_tick_ff};
            mem_wa = found_idx_ff;
            case (cmd_ff.op)
               aat_pkg::OP_ADD: begin
                  if (found_ff) begin
                     mem_we = 1'b1;
                  end else if (free_ff) begin
                     mem_we                = 1'b1;
                     mem_wa                = free_idx_ff;
                     valid_in[free_idx_ff] = 1'b1;
                     count_in              = count_ff + aat_pkg::CNT_W'(1);
                  end else begin
                     status_in = aat_pkg::ST_FULL;
                  end
               end
               aat_pkg::OP_UPDATE: begin
                  if (found_ff) begin
                     mem_we = 1'b1;
                  end else begin
                     status_in = aat_pkg::ST_NOT_FOUND;
                  end
               end
               aat_pkg::OP_DELETE: begin
                  if (found_ff) begin
                     valid_in[found_idx_ff] = 1'b0;
                     count_in               = count_ff - aat_pkg::CNT_W'(1);
                  end
               end
               default: ;
            endcase
            state_in = S_DONE;
         end

         S_DONE: begin
            if (rsp_free_i) begin
               state_in = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   // hold state; control clears on reset
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         last_tick_ff <= '0;
         issuing_ff   <= 1'b0;
         cmp_valid_ff <= 1'b0;
         valid_ff     <= '0;
         count_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         last_tick_ff <= last_tick_in;
         issuing_ff   <= issuing_in;
         cmp_valid_ff <= cmp_valid_in;
         valid_ff     <= valid_in;
         count_ff     <= count_in;
      end
      cmd_ff       <= cmd_in;
      restamp_ff   <= restamp_in;
      issue_idx_ff <= issue_idx_in;
      cmp_idx_ff   <= cmp_idx_in;
      found_ff     <= found_in;
      found_idx_ff <= found_idx_in;
      free_ff      <= free_in;
      free_idx_ff  <= free_idx_in;
      status_ff    <= status_in;
   end

   // synchronous memory, one read and one write port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      rd_data_ff <= mem[issue_idx_ff];
   end

   assign idle_o          = (state_ff == S_IDLE);
   assign done_o          = (state_ff == S_DONE) && rsp_free_i;
   assign result_o.status = status_ff;
   assign result_o.count  = count_ff;

   a_count_matches_valid: assert property (@(posedge clock) disable iff (reset)
      count_ff == aat_pkg::CNT_W'($countones(valid_ff)))
      else $error("entry count differs from valid bits");

   a_scan_in_flight: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> (issuing_ff || cmp_valid_ff))
      else $error("scan stalled with no read in flight");

   a_finish_to_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FINISH) |=> (state_ff == S_DONE))
      else $error("finish did not hand off to done");

   a_start_when_idle: assert property (@(posedge clock) disable iff (reset)
      start_i |-> (state_ff == S_IDLE))
      else $error("start while busy");

endmodule
